// File: hdl/rucb_pkg.sv
`timescale 1ns / 1ps

package rucb_pkg;

  localparam int QW         = 32;           // Q16.16 word
  localparam int FRAC       = 16;
  localparam int DIFFW      = QW + 2;       // face minus origin
  localparam int NUMW       = QW + FRAC;    // dividend magnitude
  localparam int DENW       = QW;           // divisor magnitude
  localparam int DIV_STAGES = NUMW;         // one quotient bit per stage
  localparam int TW         = NUMW + 3;     // signed distance with unbounded codes

  typedef logic signed [QW-1:0]    q_t;
  typedef logic signed [DIFFW-1:0] diff_t;
  typedef logic signed [TW-1:0]    dist_t;

  localparam diff_t Q_ONE   = diff_t'(65536);
  localparam dist_t POS_UNB = dist_t'(1) <<< (NUMW + 1);
  localparam dist_t NEG_UNB = -POS_UNB;
  localparam dist_t Q_MAX   = dist_t'(32'sh7FFF_FFFF);
  localparam dist_t Q_MIN   = -(dist_t'(1) <<< (QW - 1));

  // per-item flags carried alongside the dividers
  typedef struct packed {
    logic [5:0] neg;     // quotient sign, per lane
    logic [2:0] zero_d;  // direction component is zero
    logic [2:0] in_slab; // origin within the slab
  } side_t;

  function automatic q_t sat_q(input dist_t v);
    if (v > Q_MAX) begin
      return q_t'(32'sh7FFF_FFFF);
    end else if (v < Q_MIN) begin
      return q_t'(32'sh8000_0000);
    end
    return v[QW-1:0];
  endfunction

endpackage

// File: hdl/rucb_div.sv
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider, one quotient bit per stage.
module rucb_div
  import rucb_pkg::*;
(
  input  logic            clk,
  input  logic [NUMW-1:0] in_num,
  input  logic [DENW-1:0] in_den,
  output logic [NUMW-1:0] out_q
);

  logic [DENW-1:0] rem_r [DIV_STAGES];
  logic [NUMW-1:0] nq_r  [DIV_STAGES];
  logic [DENW-1:0] den_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [DENW-1:0] rem_in;
    logic [NUMW-1:0] nq_in;
    logic [DENW-1:0] den_in;
    logic [DENW:0]   shifted;
    logic [DENW:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = in_num;
      assign den_in = in_den;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign nq_in  = nq_r[j-1];
      assign den_in = den_r[j-1];
    end

    assign shifted = {rem_in, nq_in[NUMW-1]};
    assign trial   = shifted - {1'b0, den_in};

    always_ff @(posedge clk) begin
      den_r[j] <= den_in;
      if (!trial[DENW]) begin
        rem_r[j] <= trial[DENW-1:0];
        nq_r[j]  <= {nq_in[NUMW-2:0], 1'b1};
      end else begin
        rem_r[j] <= shifted[DENW-1:0];
        nq_r[j]  <= {nq_in[NUMW-2:0], 1'b0};
      end
    end
  end

  assign out_q = nq_r[DIV_STAGES-1];

endmodule

// File: hdl/ray_unit_cube_intersect_unit.sv
`timescale 1ns / 1ps

// Ray against the cube [-1,1]^3, slab test, signed Q16.16.
// Input: raise start with in_origin_* and in_dir_* for one cycle; the item is
// taken when start is high and busy is low. busy is always low, so one ray
// can be given every clock.
// Output: out_valid is high for exactly one cycle with out_hit, out_t_near
// and out_t_far. There is no backpressure: results must be taken as shown.
// Pipeline: 1 prep stage, 48 divider stages, one quotient bit each, then
// sign, slab order, min/max and compare/saturate stages. Throughput: one
// item per cycle, set by the six fully pipelined dividers.
// On a miss t_near and t_far both read 0x7FFFFFFF.
// Reset (rst_n low, synchronous) clears every valid bit in the pipeline;
// items in flight are dropped and data registers keep stale values.
module ray_unit_cube_intersect_unit
  import rucb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_t_near,
  output logic [31:0] out_t_far
);

  assign busy = 1'b0;

  // ---- prep: face differences and magnitudes
  q_t              o_a [3];
  q_t              d_a [3];
  logic [NUMW-1:0] num_nxt [6];
  logic [DENW-1:0] den_nxt [6];
  side_t           side_nxt;

  assign o_a[0] = in_origin_x;
  assign o_a[1] = in_origin_y;
  assign o_a[2] = in_origin_z;
  assign d_a[0] = in_dir_x;
  assign d_a[1] = in_dir_y;
  assign d_a[2] = in_dir_z;

  always_comb begin
    diff_t         o_e;
    diff_t         diff_p;
    diff_t         diff_m;
    diff_t         mag_p;
    diff_t         mag_m;
    logic [DENW:0] dmag;
    for (int i = 0; i < 3; i++) begin
      o_e    = diff_t'(o_a[i]);
      diff_p = Q_ONE - o_e;
      diff_m = -Q_ONE - o_e;
      mag_p  = diff_p[DIFFW-1] ? -diff_p : diff_p;
      mag_m  = diff_m[DIFFW-1] ? -diff_m : diff_m;
      dmag   = d_a[i][QW-1] ? -{d_a[i][QW-1], d_a[i]} : {1'b0, d_a[i]};
      num_nxt[2*i]   = {mag_p[QW-1:0], {FRAC{1'b0}}};
      num_nxt[2*i+1] = {mag_m[QW-1:0], {FRAC{1'b0}}};
      den_nxt[2*i]   = dmag[DENW-1:0];
      den_nxt[2*i+1] = dmag[DENW-1:0];
      side_nxt.neg[2*i]   = diff_p[DIFFW-1] ^ d_a[i][QW-1];
      side_nxt.neg[2*i+1] = diff_m[DIFFW-1] ^ d_a[i][QW-1];
      side_nxt.zero_d[i]  = (d_a[i] == '0);
      side_nxt.in_slab[i] = (o_e >= -Q_ONE) && (o_e <= Q_ONE);
    end
  end

  logic            p_vld_r;
  logic [NUMW-1:0] num_r [6];
  logic [DENW-1:0] den_r [6];
  side_t           p_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    p_side_r <= side_nxt;
  end

  // ---- dividers
  logic [NUMW-1:0] quo [6];

  for (genvar k = 0; k < 6; k++) begin : g_lane
    rucb_div u_div (
      .clk    (clk),
      .in_num (num_r[k]),
      .in_den (den_r[k]),
      .out_q  (quo[k])
    );
  end

  logic  vld_r  [DIV_STAGES];
  side_t side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      vld_r[0] <= p_vld_r;
      for (int j = 1; j < DIV_STAGES; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= p_side_r;
    for (int j = 1; j < DIV_STAGES; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  // ---- stage A: apply signs
  logic  a_vld_r;
  dist_t a_q_r [6];
  side_t a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      a_q_r[k] <= side_r[DIV_STAGES-1].neg[k] ? -dist_t'({1'b0, quo[k]})
                                               : dist_t'({1'b0, quo[k]});
    end
    a_side_r <= side_r[DIV_STAGES-1];
  end

  // ---- stage B: order each slab, handle zero direction
  logic  b_vld_r;
  dist_t b_en_r [3];
  dist_t b_ex_r [3];
  logic  b_ok_r;
  dist_t en_nxt [3];
  dist_t ex_nxt [3];
  logic  ok_nxt;

  always_comb begin
    ok_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (a_side_r.zero_d[i]) begin
        en_nxt[i] = NEG_UNB;
        ex_nxt[i] = POS_UNB;
        if (!a_side_r.in_slab[i]) begin
          ok_nxt = 1'b0;
        end
      end else if (a_q_r[2*i] > a_q_r[2*i+1]) begin
        en_nxt[i] = a_q_r[2*i+1];
        ex_nxt[i] = a_q_r[2*i];
      end else begin
        en_nxt[i] = a_q_r[2*i];
        ex_nxt[i] = a_q_r[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_en_r <= en_nxt;
    b_ex_r <= ex_nxt;
    b_ok_r <= ok_nxt;
  end

  // ---- stage C: largest entry, smallest exit
  logic  c_vld_r;
  dist_t c_tn_r;
  dist_t c_tf_r;
  logic  c_ok_r;
  dist_t tn_nxt;
  dist_t tf_nxt;

  always_comb begin
    tn_nxt = NEG_UNB;
    tf_nxt = POS_UNB;
    for (int i = 0; i < 3; i++) begin
      if (b_en_r[i] > tn_nxt) begin
        tn_nxt = b_en_r[i];
      end
      if (b_ex_r[i] < tf_nxt) begin
        tf_nxt = b_ex_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_tn_r <= tn_nxt;
    c_tf_r <= tf_nxt;
    c_ok_r <= b_ok_r;
  end

  // ---- stage D: hit test and saturation
  logic out_valid_r;
  logic out_hit_r;
  q_t   out_t_near_r;
  q_t   out_t_far_r;
  logic hit_nxt;

  assign hit_nxt = c_ok_r && (c_tn_r < c_tf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= hit_nxt;
    if (hit_nxt) begin
      out_t_near_r <= sat_q(c_tn_r);
      out_t_far_r  <= sat_q(c_tf_r);
    end else begin
      out_t_near_r <= q_t'(32'sh7FFF_FFFF);
      out_t_far_r  <= q_t'(32'sh7FFF_FFFF);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_t_near = out_t_near_r;
  assign out_t_far  = out_t_far_r;

endmodule
